[hdl/mesh_signed_volume_macros.svh]
// Assertion macros for the mesh_signed_volume block.
// Used by the top level only; needs nothing else.
`ifndef MESH_SIGNED_VOLUME_MACROS_SVH
`define MESH_SIGNED_VOLUME_MACROS_SVH

// same-cycle implication
`define MSV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/msv_pkg.sv]
// Shared types and constants for the mesh_signed_volume block.
// Beat structs for both channels, accumulator and divider constants.
`default_nettype none

package msv_pkg;

  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned ACC_W           = 64;
  localparam int unsigned VOL_W           = 51;
  localparam int unsigned VOL_DIV         = 6000;
  localparam int unsigned REM_W           = 13;

  localparam logic [VOL_W-1:0] VOL_MAX = 51'd1537228672809129;

  typedef struct packed {
    logic signed [FIELD_W-1:0] v0_x;
    logic signed [FIELD_W-1:0] v0_y;
    logic signed [FIELD_W-1:0] v0_z;
    logic signed [FIELD_W-1:0] v1_x;
    logic signed [FIELD_W-1:0] v1_y;
    logic signed [FIELD_W-1:0] v1_z;
    logic signed [FIELD_W-1:0] v2_x;
    logic signed [FIELD_W-1:0] v2_y;
    logic signed [FIELD_W-1:0] v2_z;
    logic                      last;
  } tri_beat_t;

  typedef struct packed {
    logic [VOL_W-1:0] volume_ml;
    logic             overflow;
  } vol_beat_t;

endpackage

`default_nettype wire

[hdl/msv_front.sv]
// Front part: accepts triangles and forms the triple product in a 4-stage pipeline.
// Depends on msv_pkg.
`default_nettype none

module msv_front #(
  parameter int unsigned COORD_BITS = msv_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire msv_pkg::tri_beat_t          in_beat_i,
  output logic                             tp_valid_o,
  input  wire logic                        tp_ready_i,
  output logic signed [3*COORD_BITS+2:0]   tp_o,
  output logic                             tp_last_o
);
  import msv_pkg::*;

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned PW  = 2 * CW;
  localparam int unsigned XW  = 2 * CW + 1;
  localparam int unsigned MW  = 3 * CW + 1;
  localparam int unsigned TW  = 3 * CW + 3;
  localparam int unsigned NST = 4;

  function automatic logic signed [CW-1:0] coord(input logic [FIELD_W-1:0] f);
    logic [CW+FIELD_W-1:0] ext;
    ext = {{CW{1'b0}}, f};
    return $signed(ext[CW-1:0]);
  endfunction

  logic signed [CW-1:0] x0, y0, z0, x1, y1, z1;

  logic [NST-1:0] valid_q;
  logic           adv;

  logic signed [PW-1:0] yz_q, zy_q, zx_q, xz_q, xy_q, yx_q;
  logic signed [XW-1:0] cx_q, cy_q, cz_q;
  logic signed [MW-1:0] mx_q, my_q, mz_q;
  logic signed [TW-1:0] t_q;
  logic signed [CW-1:0] x2_s1_q, y2_s1_q, z2_s1_q, x2_s2_q, y2_s2_q, z2_s2_q;
  logic [NST-1:0]       last_q;

  always_comb begin
    x0 = coord(in_beat_i.v0_x);
    y0 = coord(in_beat_i.v0_y);
    z0 = coord(in_beat_i.v0_z);
    x1 = coord(in_beat_i.v1_x);
    y1 = coord(in_beat_i.v1_y);
    z1 = coord(in_beat_i.v1_z);
  end

  // hold the whole pipe while the queue refuses the oldest beat
  assign adv        = !(valid_q[NST-1] && !tp_ready_i);
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yz_q    <= PW'(y0) * PW'(z1);
      zy_q    <= PW'(z0) * PW'(y1);
      zx_q    <= PW'(z0) * PW'(x1);
      xz_q    <= PW'(x0) * PW'(z1);
      xy_q    <= PW'(x0) * PW'(y1);
      yx_q    <= PW'(y0) * PW'(x1);
      x2_s1_q <= coord(in_beat_i.v2_x);
      y2_s1_q <= coord(in_beat_i.v2_y);
      z2_s1_q <= coord(in_beat_i.v2_z);

      cx_q    <= XW'(yz_q) - XW'(zy_q);
      cy_q    <= XW'(zx_q) - XW'(xz_q);
      cz_q    <= XW'(xy_q) - XW'(yx_q);
      x2_s2_q <= x2_s1_q;
      y2_s2_q <= y2_s1_q;
      z2_s2_q <= z2_s1_q;

      mx_q    <= MW'(cx_q) * MW'(x2_s2_q);
      my_q    <= MW'(cy_q) * MW'(y2_s2_q);
      mz_q    <= MW'(cz_q) * MW'(z2_s2_q);

      t_q     <= TW'(mx_q) + TW'(my_q) + TW'(mz_q);
      last_q  <= {last_q[NST-2:0], in_beat_i.last};
    end
  end

  assign tp_valid_o = valid_q[NST-1];
  assign tp_o       = t_q;
  assign tp_last_o  = last_q[NST-1];

endmodule

`default_nettype wire

[hdl/msv_queue.sv]
// Small register queue between the front and back parts.
// Standalone; no package use.
`default_nettype none

module msv_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_ready_o,
  input  wire logic [W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  wire logic         pop_ready_i,
  output logic [W-1:0]      pop_data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [W-1:0]     mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != FULL_CNT);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + AW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[hdl/msv_back.sv]
// Back part: saturating 64-bit accumulator and divide by 6000 in 16-bit quotient digits.
// Each digit takes a reciprocal multiply step and a remainder step. Depends on msv_pkg.
`default_nettype none

module msv_back #(
  parameter int unsigned TP_W = 51
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   tp_valid_i,
  output logic                        tp_ready_o,
  input  wire logic signed [TP_W-1:0] tp_i,
  input  wire logic                   tp_last_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output msv_pkg::vol_beat_t          out_beat_o,
  output logic                        busy_o
);
  import msv_pkg::*;

  localparam int unsigned DIG_W    = 16;
  localparam int unsigned DIGITS   = ACC_W / DIG_W;
  localparam int unsigned DCNT_W   = $clog2(DIGITS);
  localparam int unsigned TRIAL_W  = REM_W + DIG_W;
  localparam int unsigned RECIP_SH = TRIAL_W + REM_W;
  localparam int unsigned RECIP_W  = RECIP_SH - REM_W + 1;
  localparam int unsigned PROD_W   = TRIAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(VOL_DIV) - 64'd1) / 64'(VOL_DIV));
  localparam logic [TRIAL_W-1:0] DIV_T    = TRIAL_W'(VOL_DIV);
  localparam logic [DCNT_W-1:0]  LAST_DIG = DCNT_W'(DIGITS - 1);
  localparam logic [ACC_W-1:0]   ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]   ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {ST_ACC, ST_MUL, ST_REM, ST_OUT} state_e;

  state_e             state_q;
  logic [ACC_W-1:0]   acc_q;
  logic               sat_q;
  logic               ovf_hold_q;
  logic [ACC_W-1:0]   num_q;
  logic [REM_W-1:0]   rem_q;
  logic [TRIAL_W-1:0] trial_q;
  logic [DIG_W-1:0]   qd_q;
  logic [VOL_W-1:0]   quo_q;
  logic [DCNT_W-1:0]  dig_q;
  logic               out_valid_q;
  vol_beat_t          out_q;

  logic [ACC_W:0]     sum_w;
  logic               ovf;
  logic [ACC_W-1:0]   sum_sat;
  logic [ACC_W-1:0]   mag;
  logic [TRIAL_W-1:0] trial;
  logic               pop;
  logic               out_free;
  logic               load_out;

  always_comb begin
    sum_w   = {acc_q[ACC_W-1], acc_q} + {{(ACC_W + 1 - TP_W){tp_i[TP_W-1]}}, tp_i};
    ovf     = sum_w[ACC_W] ^ sum_w[ACC_W-1];
    sum_sat = ovf ? (sum_w[ACC_W] ? ACC_MIN : ACC_MAX) : sum_w[ACC_W-1:0];
    mag     = sum_sat[ACC_W-1] ? (~sum_sat + ACC_W'(1)) : sum_sat;
    trial   = {rem_q, num_q[ACC_W-1 -: DIG_W]};
  end

  assign tp_ready_o  = (state_q == ST_ACC);
  assign pop         = tp_valid_i && tp_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign load_out    = (state_q == ST_OUT) && out_free;
  assign busy_o      = (state_q != ST_ACC);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      ovf_hold_q  <= 1'b0;
      num_q       <= '0;
      rem_q       <= '0;
      trial_q     <= '0;
      qd_q        <= '0;
      quo_q       <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= load_out || (out_valid_q && !out_ready_i);
      unique case (state_q)
        ST_ACC: begin
          if (pop) begin
            if (tp_last_i) begin
              acc_q      <= '0;
              sat_q      <= 1'b0;
              ovf_hold_q <= sat_q | ovf;
              num_q      <= mag;
              rem_q      <= '0;
              dig_q      <= '0;
              state_q    <= ST_MUL;
            end else begin
              acc_q <= sum_sat;
              sat_q <= sat_q | ovf;
            end
          end
        end
        ST_MUL: begin
          qd_q    <= DIG_W'((PROD_W'(trial) * PROD_W'(RECIP)) >> RECIP_SH);
          trial_q <= trial;
          num_q   <= {num_q[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}};
          state_q <= ST_REM;
        end
        ST_REM: begin
          rem_q   <= REM_W'(trial_q - TRIAL_W'(qd_q) * DIV_T);
          quo_q   <= {quo_q[VOL_W-DIG_W-1:0], qd_q};
          dig_q   <= dig_q + DCNT_W'(1);
          state_q <= (dig_q == LAST_DIG) ? ST_OUT : ST_MUL;
        end
        ST_OUT: begin
          if (load_out) begin
            out_q   <= '{volume_ml: quo_q, overflow: ovf_hold_q};
            state_q <= ST_ACC;
          end
        end
        default: begin
          state_q <= ST_ACC;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/mesh_signed_volume.sv]
// Top level of the mesh_signed_volume block: front pipeline, queue, back part.
// Depends on msv_pkg, msv_front, msv_queue, msv_back and the assertion macros.
//
//   channel  dir  handshake               beat
//   in       in   in_valid_i/in_ready_o   tri_beat_t: three vertices and last
//   out      out  out_valid_o/out_ready_i vol_beat_t: volume_ml and overflow
//
// One triangle a cycle enters a 4-stage triple product pipeline while the queue takes products; the back
// part adds one product a cycle into the saturating accumulator while it is not dividing.
// After a last triangle the back part divides by 6000 in four 16-bit quotient
// digits, each a multiply step and a remainder step, then loads the output register.
// The queue holds up to QUEUE_DEPTH (default four) products while the back divides; then the input stalls.
// Reset is asynchronous and takes effect at once; no clearing pass.
// A held result stalls the back only once the next mesh's divide is done.
`default_nettype none
`include "mesh_signed_volume_macros.svh"

module mesh_signed_volume #(
  parameter int unsigned COORD_BITS  = msv_pkg::COORD_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = msv_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire msv_pkg::tri_beat_t in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output msv_pkg::vol_beat_t      out_beat_o
);
  import msv_pkg::*;

  localparam int unsigned TP_W = 3 * COORD_BITS + 3;

  logic                   f_valid, f_ready, f_last;
  logic signed [TP_W-1:0] f_tp;
  logic                   q_valid, q_ready;
  logic [TP_W:0]          q_data;
  logic                   bk_busy;

  msv_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .tp_valid_o (f_valid),
    .tp_ready_i (f_ready),
    .tp_o       (f_tp),
    .tp_last_o  (f_last)
  );

  msv_queue #(
    .W    (TP_W + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_last, f_tp}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  msv_back #(
    .TP_W(TP_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tp_valid_i  (q_valid),
    .tp_ready_o  (q_ready),
    .tp_i        ($signed(q_data[TP_W-1:0])),
    .tp_last_i   (q_data[TP_W]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .busy_o      (bk_busy)
  );

  `MSV_ASSERT_IMP(a_no_pop_while_div, clk_i, rst_ni, bk_busy, !q_ready, "pop during divide")
  `MSV_ASSERT_IMP(a_result_after_div, clk_i, rst_ni, $rose(out_valid_o), $past(bk_busy), "result without divide")
  `MSV_ASSERT_IMP(a_volume_bound, clk_i, rst_ni, out_valid_o, out_beat_o.volume_ml <= VOL_MAX, "volume out of range")

endmodule

`default_nettype wire
